// ===== sv/hfg_pkg.sv =====
`timescale 1ns / 1ps
// hfg_pkg: shared types and constants of the heightfield facet generator.
// No dependencies.
package hfg_pkg;

  localparam int COORD_W = 40;
  localparam int ELEV_W  = 24;
  localparam int STEP_W  = 24;
  localparam int GCOL_W  = 13;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 3'd4;

  localparam logic REC_NORMAL = 1'b0;
  localparam logic REC_VERTEX = 1'b1;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PREP,
    ST_NMUL,
    ST_SHIFT,
    ST_SQ,
    ST_SQRT,
    ST_DLOAD,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ===== sv/heightfield_facet_generator.sv =====
`timescale 1ns / 1ps
// heightfield_facet_generator: raster heightfield to facet records (normal + 3 vertices, x2).
// Depends on hfg_pkg. Holds the line store memory and the shared arithmetic units.
// An edge sample (row 0 or column 0) passes ST_LOAD only and gives no records.
// An inner sample passes ST_LOAD, ST_PREP, then per normal ST_NMUL, ST_SHIFT (normalize),
// ST_SQ, ST_SQRT and ST_DLOAD/ST_DIV per component, then ST_OUT (a zero normal skips from ST_SHIFT);
// per normal a 32-step square root and a bit-serial divider.
// One sample in flight at a time; the last record may still wait while the next is accepted.
// Reset (synchronous, rst_n low): counters, neighbor samples and registers to defaults;
// line store contents are not cleared.
module heightfield_facet_generator #(
  parameter int MAX_COLUMNS = 4096,
  parameter int MAX_ROWS    = 65536
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [23:0]   in_tdata,   // [23:0] elevation
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [119:0]  out_tdata,  // [39:0] coord_x, [79:40] coord_y, [119:80] coord_z
  output logic          out_tuser,  // [0] record_kind
  output logic          out_tlast,
  input  logic          cfg_wr_en,
  input  logic [hfg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfg_pkg::COORD_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int EW = (hfg_pkg::GCOL_W > CW + 1) ? hfg_pkg::GCOL_W : CW + 1;

  // configuration
  logic signed [39:0] xo_r, yo_r;
  logic signed [23:0] sx_r, sy_r;
  logic [hfg_pkg::GCOL_W-1:0] gcol_r;

  // control
  hfg_pkg::state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       tri_r, tri_nxt;
  logic [1:0] k_r, k_nxt;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic active_r;
  logic signed [23:0] left_r, ul_r;

  // line store
  logic [23:0] row_mem [MAX_COLUMNS];
  logic [23:0] rd_q;

  // datapath
  logic [CW-1:0] cr_r;
  logic [RW-1:0] rr_r;
  logic signed [23:0] za_r, zb_r, zc_r, zd_r;
  logic signed [39:0] x0_r, x1_r, y0_r, y1_r;
  logic signed [48:0] sxsy_r;
  logic signed [24:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [48:0] mul_p_r;
  logic [47:0] u_r [3];
  logic        neg_r [2][3];
  logic [30:0] nq_r [2][3];
  logic [30:0] sq_a;
  logic [61:0] sq_p_r;
  logic [63:0] sum_r, v_r, res_r, bit_r;
  logic [31:0] rem_r;
  logic [30:0] nlo_r, q_r;

  logic signed [39:0] ox_r, oy_r, oz_r;
  logic okind_r, olast_r, out_tvalid_r;

  logic acc, out_load;
  logic [EW-1:0] gc_e, ncols, col_inc;
  logic signed [24:0] dz0, dz1;
  logic signed [49:0] vsum;
  logic signed [39:0] vsat;
  logic [47:0] m_max;
  logic [63:0] sq_t;
  logic [61:0] num;
  logic [32:0] rs;
  logic        ge;
  logic [30:0] qn;
  logic [31:0] len;

  function automatic logic [47:0] mag48(input logic signed [48:0] p);
    logic signed [48:0] n;
    n = -p;
    return p[48] ? n[47:0] : p[47:0];
  endfunction

  function automatic logic signed [39:0] nval(input logic ng, input logic [30:0] q);
    logic signed [39:0] e;
    e = $signed(40'(q));
    return ng ? -e : e;
  endfunction

  assign acc       = in_tvalid && in_tready;
  assign in_tready = (state_r == hfg_pkg::ST_IDLE);
  assign out_load  = (state_r == hfg_pkg::ST_OUT) && (!out_tvalid_r || out_tready);

  assign gc_e    = EW'(gcol_r);
  assign ncols   = (gc_e < EW'(2)) ? EW'(2) :
                   ((gc_e > EW'(MAX_COLUMNS)) ? EW'(MAX_COLUMNS) : gc_e);
  assign col_inc = EW'(col_r) + EW'(1);

  assign dz0 = tri_r ? (25'(zd_r) - 25'(zc_r)) : (25'(zb_r) - 25'(za_r));
  assign dz1 = tri_r ? (25'(zd_r) - 25'(zb_r)) : (25'(zc_r) - 25'(za_r));

  always_comb begin
    mul_a = '0;
    mul_b = sx_r;
    if (state_r == hfg_pkg::ST_PREP) begin
      case (cnt_r)
        5'd0: begin
          mul_a = $signed(25'(cr_r - CW'(1)));
          mul_b = sx_r;
        end
        5'd1: begin
          mul_a = $signed(25'(cr_r));
          mul_b = sx_r;
        end
        5'd2: begin
          mul_a = $signed(25'(rr_r - RW'(1)));
          mul_b = sy_r;
        end
        5'd3: begin
          mul_a = $signed(25'(rr_r));
          mul_b = sy_r;
        end
        default: begin
          mul_a = 25'(sx_r);
          mul_b = sy_r;
        end
      endcase
    end else if (cnt_r == 5'd0) begin
      mul_a = dz0;
      mul_b = sy_r;
    end else begin
      mul_a = dz1;
      mul_b = sx_r;
    end
  end

  // vertex coordinate: origin + index*step + floor(step/2), saturated
  always_comb begin
    if (cnt_r == 5'd1 || cnt_r == 5'd2) begin
      vsum = 50'(xo_r) + 50'(mul_p_r) + 50'(sx_r >>> 1);
    end else begin
      vsum = 50'(yo_r) + 50'(mul_p_r) + 50'(sy_r >>> 1);
    end
    if (vsum[49:39] != {11{vsum[39]}}) begin
      vsat = vsum[49] ? hfg_pkg::COORD_MIN : hfg_pkg::COORD_MAX;
    end else begin
      vsat = vsum[39:0];
    end
  end

  always_comb begin
    m_max = u_r[0];
    if (u_r[1] > m_max) m_max = u_r[1];
    if (u_r[2] > m_max) m_max = u_r[2];
  end

  assign sq_a = (cnt_r == 5'd0) ? u_r[0][30:0] : ((cnt_r == 5'd1) ? u_r[1][30:0] : u_r[2][30:0]);
  assign sq_t = res_r + bit_r;
  assign len  = res_r[31:0];
  assign num  = 62'({u_r[k_r][30:0], 30'd0}) + 62'(len >> 1);
  assign rs   = {rem_r, nlo_r[30]};
  assign ge   = (rs >= {1'b0, len});
  assign qn   = {q_r[29:0], ge};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    tri_nxt   = tri_r;
    k_nxt     = k_r;
    case (state_r)
      hfg_pkg::ST_IDLE: begin
        if (acc) state_nxt = hfg_pkg::ST_LOAD;
      end
      hfg_pkg::ST_LOAD: begin
        cnt_nxt   = '0;
        tri_nxt   = 1'b0;
        state_nxt = active_r ? hfg_pkg::ST_PREP : hfg_pkg::ST_IDLE;
      end
      hfg_pkg::ST_PREP: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd5) begin
          cnt_nxt   = '0;
          state_nxt = hfg_pkg::ST_NMUL;
        end
      end
      hfg_pkg::ST_NMUL: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd2) begin
          cnt_nxt   = '0;
          state_nxt = hfg_pkg::ST_SHIFT;
        end
      end
      hfg_pkg::ST_SHIFT: begin
        if (m_max == '0) begin
          cnt_nxt = '0;
          if (tri_r) begin
            state_nxt = hfg_pkg::ST_OUT;
          end else begin
            tri_nxt   = 1'b1;
            state_nxt = hfg_pkg::ST_NMUL;
          end
        end else if (m_max[47:31] == '0 && m_max[30]) begin
          cnt_nxt   = '0;
          state_nxt = hfg_pkg::ST_SQ;
        end
      end
      hfg_pkg::ST_SQ: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd3) begin
          cnt_nxt   = '0;
          state_nxt = hfg_pkg::ST_SQRT;
        end
      end
      hfg_pkg::ST_SQRT: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          k_nxt     = '0;
          state_nxt = hfg_pkg::ST_DLOAD;
        end
      end
      hfg_pkg::ST_DLOAD: begin
        cnt_nxt   = '0;
        state_nxt = hfg_pkg::ST_DIV;
      end
      hfg_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          cnt_nxt = '0;
          if (k_r != 2'd2) begin
            k_nxt     = k_r + 2'd1;
            state_nxt = hfg_pkg::ST_DLOAD;
          end else if (tri_r) begin
            state_nxt = hfg_pkg::ST_OUT;
          end else begin
            tri_nxt   = 1'b1;
            state_nxt = hfg_pkg::ST_NMUL;
          end
        end
      end
      hfg_pkg::ST_OUT: begin
        if (out_load) begin
          cnt_nxt = cnt_r + 5'd1;
          if (cnt_r == 5'd7) begin
            cnt_nxt   = '0;
            state_nxt = hfg_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = hfg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hfg_pkg::ST_IDLE;
      cnt_r        <= '0;
      tri_r        <= 1'b0;
      k_r          <= '0;
      col_r        <= '0;
      row_r        <= '0;
      active_r     <= 1'b0;
      left_r       <= '0;
      ul_r         <= '0;
      out_tvalid_r <= 1'b0;
      xo_r         <= '0;
      yo_r         <= '0;
      sx_r         <= 24'sd256;
      sy_r         <= 24'sd256;
      gcol_r       <= 13'd4096;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      tri_r   <= tri_nxt;
      k_r     <= k_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          hfg_pkg::CFG_X_ORIGIN:     xo_r   <= cfg_data;
          hfg_pkg::CFG_Y_ORIGIN:     yo_r   <= cfg_data;
          hfg_pkg::CFG_STEP_X:       sx_r   <= cfg_data[23:0];
          hfg_pkg::CFG_STEP_Y:       sy_r   <= cfg_data[23:0];
          hfg_pkg::CFG_GRID_COLUMNS: gcol_r <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (acc) begin
        active_r <= (row_r != '0) && (col_r != '0);
        left_r   <= in_tdata;
        if (col_inc >= ncols) begin
          col_r <= '0;
          row_r <= (row_r == RW'(MAX_ROWS - 1)) ? '0 : row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
      if (state_r == hfg_pkg::ST_LOAD) ul_r <= rd_q;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // line store, read-before-write
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_q          <= row_mem[col_r];
      row_mem[col_r] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
    sq_p_r  <= sq_a * sq_a;
    if (acc) begin
      cr_r <= col_r;
      rr_r <= row_r;
      zd_r <= in_tdata;
      zc_r <= left_r;
      za_r <= ul_r;
    end
    case (state_r)
      hfg_pkg::ST_LOAD: zb_r <= rd_q;
      hfg_pkg::ST_PREP: begin
        case (cnt_r)
          5'd1: x0_r <= vsat;
          5'd2: x1_r <= vsat;
          5'd3: y0_r <= vsat;
          5'd4: y1_r <= vsat;
          5'd5: sxsy_r <= mul_p_r;
          default: ;
        endcase
      end
      hfg_pkg::ST_NMUL: begin
        if (cnt_r == 5'd1) begin
          u_r[0]          <= mag48(mul_p_r);
          neg_r[tri_r][0] <= mul_p_r[48];
        end else if (cnt_r == 5'd2) begin
          u_r[1]          <= mag48(mul_p_r);
          neg_r[tri_r][1] <= mul_p_r[48];
          u_r[2]          <= mag48(sxsy_r);
          neg_r[tri_r][2] <= !sxsy_r[48] && (sxsy_r != '0);
        end
      end
      hfg_pkg::ST_SHIFT: begin
        if (m_max == '0) begin
          nq_r[tri_r][0] <= '0;
          nq_r[tri_r][1] <= '0;
          nq_r[tri_r][2] <= '0;
        end else if (!m_max[30] && m_max[47:31] == '0) begin
          u_r[0] <= u_r[0] << 1;
          u_r[1] <= u_r[1] << 1;
          u_r[2] <= u_r[2] << 1;
        end else if (m_max[47:31] != '0) begin
          u_r[0] <= u_r[0] >> 1;
          u_r[1] <= u_r[1] >> 1;
          u_r[2] <= u_r[2] >> 1;
        end
      end
      hfg_pkg::ST_SQ: begin
        if (cnt_r == 5'd0) begin
          sum_r <= '0;
        end else if (cnt_r == 5'd3) begin
          v_r   <= sum_r + 64'(sq_p_r);
          res_r <= '0;
          bit_r <= 64'd1 << 62;
        end else begin
          sum_r <= sum_r + 64'(sq_p_r);
        end
      end
      hfg_pkg::ST_SQRT: begin
        if (v_r >= sq_t) begin
          v_r   <= v_r - sq_t;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      hfg_pkg::ST_DLOAD: begin
        rem_r <= 32'(num[61:31]);
        nlo_r <= num[30:0];
        q_r   <= '0;
      end
      hfg_pkg::ST_DIV: begin
        rem_r <= ge ? 32'(rs - {1'b0, len}) : rs[31:0];
        nlo_r <= nlo_r << 1;
        q_r   <= qn;
        if (cnt_r == 5'd30) nq_r[tri_r][k_r] <= qn;
      end
      default: ;
    endcase
    if (out_load) begin
      okind_r <= hfg_pkg::REC_VERTEX;
      olast_r <= 1'b0;
      case (cnt_r[2:0])
        3'd0: begin
          okind_r <= hfg_pkg::REC_NORMAL;
          ox_r <= nval(neg_r[0][0], nq_r[0][0]);
          oy_r <= nval(neg_r[0][1], nq_r[0][1]);
          oz_r <= nval(neg_r[0][2], nq_r[0][2]);
        end
        3'd1: begin
          ox_r <= x0_r; oy_r <= y0_r; oz_r <= 40'(za_r);
        end
        3'd2, 3'd6: begin
          ox_r <= x1_r; oy_r <= y0_r; oz_r <= 40'(zb_r);
        end
        3'd4: begin
          okind_r <= hfg_pkg::REC_NORMAL;
          ox_r <= nval(neg_r[1][0], nq_r[1][0]);
          oy_r <= nval(neg_r[1][1], nq_r[1][1]);
          oz_r <= nval(neg_r[1][2], nq_r[1][2]);
        end
        3'd5: begin
          ox_r <= x1_r; oy_r <= y1_r; oz_r <= 40'(zd_r);
        end
        default: begin
          ox_r <= x0_r; oy_r <= y1_r; oz_r <= 40'(zc_r);
          olast_r <= (cnt_r[2:0] == 3'd7);
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {oz_r, oy_r, ox_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> state_r == hfg_pkg::ST_LOAD)
    else $error("accepted sample did not start line store load");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hfg_pkg::ST_SQ |-> (m_max[47:31] == '0 && m_max[30]))
    else $error("normalized magnitude out of range");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hfg_pkg::ST_DLOAD |-> (res_r[63:32] == '0 && res_r[31:30] != 2'b00))
    else $error("square root out of range");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hfg_pkg::ST_DIV && cnt_r == 5'd30) |-> qn <= 31'h4000_0000)
    else $error("normal component above unity");

endmodule

// ===== tb/heightfield_facet_generator_checker.sv =====
`timescale 1ns / 1ps
// Checker for heightfield_facet_generator: watches the config, sample and record channels,
// predicts the facet records of every accepted sample and compares them in order.
// Depends on hfg_pkg.
module heightfield_facet_generator_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tready,
  input  logic [23:0]   in_tdata,
  input  logic          out_tvalid,
  input  logic          out_tready,
  input  logic [119:0]  out_tdata,
  input  logic          out_tuser,
  input  logic          out_tlast,
  input  logic          cfg_wr_en,
  input  logic [hfg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfg_pkg::COORD_W-1:0]   cfg_data,
  output int            pending,
  output int            errors
);
  import hfg_pkg::*;

  localparam int NCOL = 4096;
  localparam int NROW = 65536;
  localparam longint C_MAX = 64'sd549755813887;
  localparam longint C_MIN = -64'sd549755813888;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               last;
  } facet_rec_t;

  facet_rec_t facet_q[$];

  longint org_x, org_y, pitch_x, pitch_y;
  int     cols_cfg;
  logic signed [ELEV_W-1:0] line_mem [NCOL];
  logic signed [ELEV_W-1:0] left_z, upleft_z;
  int     col_pos, row_pos;

  function automatic longint clip40(longint v);
    if (v > C_MAX) return C_MAX;
    if (v < C_MIN) return C_MIN;
    return v;
  endfunction

  function automatic longint half_floor(longint v);
    return v >= 0 ? v / 2 : -((-v + 1) / 2);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  task automatic unit_vec(input longint n0, n1, n2, output longint r0, r1, r2);
    longint unsigned u [3];
    longint          n [3];
    longint unsigned m, acc, len, q;
    longint          r [3];
    n[0] = n0; n[1] = n1; n[2] = n2;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = n[i] < 0 ? longint'(-n[i]) : n[i];
      if (u[i] > m) m = u[i];
    end
    if (m == 0) begin
      r0 = 0; r1 = 0; r2 = 0;
      return;
    end
    while (m < (64'h1 << 30)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) u[i] <<= 1;
    end
    while (m >= (64'h1 << 31)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) u[i] >>= 1;
    end
    acc = 0;
    for (int i = 0; i < 3; i++) acc += u[i] * u[i];
    len = int_sqrt(acc);
    for (int i = 0; i < 3; i++) begin
      q = ((u[i] << 30) + (len >> 1)) / len;
      r[i] = n[i] < 0 ? -longint'(q) : longint'(q);
    end
    r0 = r[0]; r1 = r[1]; r2 = r[2];
  endtask

  function automatic facet_rec_t mk(logic k, longint x, longint y, longint z, logic l);
    facet_rec_t f;
    f.kind = k; f.x = x[39:0]; f.y = y[39:0]; f.z = z[39:0]; f.last = l;
    return f;
  endfunction

  task automatic predict_facets(input logic signed [ELEV_W-1:0] sample);
    int     nc, c, r;
    longint za, zb, zc, zd, x0, x1, y0, y1, a, b, d;
    logic signed [ELEV_W-1:0] up;
    nc = cols_cfg < 2 ? 2 : (cols_cfg > NCOL ? NCOL : cols_cfg);
    c = col_pos >= NCOL ? NCOL - 1 : col_pos;
    r = row_pos;
    up = line_mem[c];
    if (r >= 1 && c >= 1) begin
      za = upleft_z; zb = up; zc = left_z; zd = sample;
      x0 = clip40(org_x + longint'(c - 1) * pitch_x + half_floor(pitch_x));
      x1 = clip40(org_x + longint'(c) * pitch_x + half_floor(pitch_x));
      y0 = clip40(org_y + longint'(r - 1) * pitch_y + half_floor(pitch_y));
      y1 = clip40(org_y + longint'(r) * pitch_y + half_floor(pitch_y));
      unit_vec(pitch_y * (zb - za), pitch_x * (zc - za), -(pitch_x * pitch_y), a, b, d);
      facet_q.push_back(mk(REC_NORMAL, a, b, d, 1'b0));
      facet_q.push_back(mk(REC_VERTEX, x0, y0, za, 1'b0));
      facet_q.push_back(mk(REC_VERTEX, x1, y0, zb, 1'b0));
      facet_q.push_back(mk(REC_VERTEX, x0, y1, zc, 1'b0));
      unit_vec(-(pitch_y * (zc - zd)), -(pitch_x * (zb - zd)), -(pitch_x * pitch_y),
               a, b, d);
      facet_q.push_back(mk(REC_NORMAL, a, b, d, 1'b0));
      facet_q.push_back(mk(REC_VERTEX, x1, y1, zd, 1'b0));
      facet_q.push_back(mk(REC_VERTEX, x1, y0, zb, 1'b0));
      facet_q.push_back(mk(REC_VERTEX, x0, y1, zc, 1'b1));
    end
    upleft_z = up;
    left_z = sample;
    line_mem[c] = sample;
    if (c + 1 >= nc) begin
      col_pos = 0;
      row_pos = (r + 1) % NROW;
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk) begin
    facet_rec_t want, got;
    if (!rst_n) begin
      org_x = 0; org_y = 0; pitch_x = 256; pitch_y = 256; cols_cfg = 4096;
      left_z = '0; upleft_z = '0; col_pos = 0; row_pos = 0;
      facet_q.delete();
      errors = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[39:0], out_tdata[79:40], out_tdata[119:80], out_tlast};
        if (facet_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected record transfer: %h", got);
        end else begin
          want = facet_q.pop_front();
          if (want !== got) begin
            errors++;
            if (errors <= 10)
              $display("record mismatch: kind %0d/%0d x %h/%h y %h/%h z %h/%h last %0d/%0d",
                       want.kind, got.kind, want.x, got.x, want.y, got.y,
                       want.z, got.z, want.last, got.last);
          end
        end
      end
      if (in_tvalid && in_tready) predict_facets(in_tdata);
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_X_ORIGIN:     org_x = longint'($signed(cfg_data));
          CFG_Y_ORIGIN:     org_y = longint'($signed(cfg_data));
          CFG_STEP_X:       pitch_x = longint'($signed(cfg_data[STEP_W-1:0]));
          CFG_STEP_Y:       pitch_y = longint'($signed(cfg_data[STEP_W-1:0]));
          CFG_GRID_COLUMNS: cols_cfg = int'(cfg_data[GCOL_W-1:0]);
          default: ;
        endcase
      end
    end
    pending = facet_q.size();
  end

endmodule

// ===== tb/heightfield_facet_generator_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for heightfield_facet_generator: drives config phases and elevation
// streams with random gaps and backpressure; checking is in heightfield_facet_generator_checker.
module heightfield_facet_generator_tb;

  localparam int SAFE_COL = 8;        // line store columns written before any row >= 1
  localparam int CYCLE_LIMIT = 2000000;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [23:0]   in_tdata;
  logic          out_tvalid;
  logic          out_tready;
  logic [119:0]  out_tdata;
  logic          out_tuser;
  logic          out_tlast;
  logic          cfg_wr_en;
  logic [hfg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hfg_pkg::COORD_W-1:0]   cfg_data;
  int            pending;
  int            errors;
  int            cycles;
  bit            calm;
  int            col_mirror;
  int            width_eff;

  heightfield_facet_generator u_top (.*);

  heightfield_facet_generator_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_tready <= calm || ($urandom_range(99) >= 37);
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint C_MAXV();
    return 64'sd549755813887;
  endfunction

  task automatic send_sample(input logic [23:0] z);
    in_tvalid <= 1'b1;
    in_tdata  <= z;
    do @(posedge clk); while (!in_tready);
    col_mirror = (col_mirror + 1 >= width_eff) ? 0 : col_mirror + 1;
    if (!calm && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_grid(input longint xo, yo, sx, sy, input int cols);
    cfg_wr_en <= 1'b1;
    cfg_index <= hfg_pkg::CFG_X_ORIGIN;     cfg_data <= xo[39:0]; @(posedge clk);
    cfg_index <= hfg_pkg::CFG_Y_ORIGIN;     cfg_data <= yo[39:0]; @(posedge clk);
    cfg_index <= hfg_pkg::CFG_STEP_X;       cfg_data <= sx[39:0]; @(posedge clk);
    cfg_index <= hfg_pkg::CFG_STEP_Y;       cfg_data <= sy[39:0]; @(posedge clk);
    cfg_index <= hfg_pkg::CFG_GRID_COLUMNS; cfg_data <= 40'(cols); @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    width_eff = cols < 2 ? 2 : (cols > 4096 ? 4096 : cols);
  endtask

  function automatic logic [23:0] rand_elev(input int mode);
    case (mode)
      0:       return 24'($urandom);
      1:       return 24'($urandom_range(0, 2047) - 1024);
      default: return 24'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic longint rand_wide(input int lim);
    if ($urandom_range(3) == 0) return longint'($signed(40'({$urandom, $urandom})));
    return longint'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  initial begin
    int  sent, nitems, mode, ph, cols;
    logic [23:0] z;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_index = hfg_pkg::CFG_X_ORIGIN;
    cfg_data = '0;
    calm = 1'b0;
    col_mirror = 0;
    width_eff = 4096;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // row 0 at the reset width writes the first SAFE_COL line store columns
    for (int i = 0; i < SAFE_COL; i++)
      send_sample(i[0] ? 24'h7FFFFF : 24'h800000);
    drain();
    // width lowered mid-row: the next sample ends row 0
    set_grid(0, 0, 256, 256, 2);
    send_sample(24'h000000);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h000000);
    send_sample(24'h7FFFFF);
    drain();
    // zero spacing gives zero normals
    set_grid(0, 0, 0, 0, 3);
    for (int i = 0; i < 4; i++) send_sample(24'h000123);
    drain();
    set_grid(C_MAXV(), C_MAXV(), 8388607, 8388607, 1);
    send_sample(24'h7FFFFF); send_sample(24'h000000); send_sample(24'h800000);
    drain();
    set_grid(-64'sd549755813888, -64'sd549755813888, -8388608, -8388608, 2);
    send_sample(24'h800000); send_sample(24'h7FFFFF); send_sample(24'h000001);
    drain();
    set_grid(1000, -1000, 300, -300, 8191);
    send_sample(24'h000010); send_sample(24'hFFFFF0);
    drain();

    sent = 0;
    ph = 0;
    while (sent < 80) begin
      calm = (ph == 2);
      mode = $urandom_range(0, 2);
      if ($urandom_range(5) == 0 && col_mirror < SAFE_COL) begin
        cols = $urandom_range(0, 1) ? 4096 : $urandom_range(4097, 8191);
        nitems = $urandom_range(1, SAFE_COL - col_mirror);
      end else begin
        cols = $urandom_range(0, SAFE_COL + 1);
        nitems = $urandom_range(8, 20);
      end
      set_grid(rand_wide(100000), rand_wide(100000),
               $urandom_range(0, 3) == 0 ? longint'($signed(24'($urandom)))
                                         : longint'($urandom_range(0, 1024)) - 512,
               $urandom_range(0, 3) == 0 ? longint'($signed(24'($urandom)))
                                         : longint'($urandom_range(0, 1024)) - 512,
               cols);
      for (int i = 0; i < nitems; i++) begin
        z = rand_elev($urandom_range(0, 5) == 0 ? 0 : mode);
        send_sample(z);
      end
      sent += nitems;
      ph++;
      drain();
    end
    calm = 1'b0;

    repeat (400) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
